FILE: rtl/core/mtme_pkg.sv
// ----------------------------------------------------------------------------
// Transform matrix engine package
// Item types, kind codes and queue depths shared by the engine's modules.
// ----------------------------------------------------------------------------
package mtme_pkg;

  localparam logic [2:0] KIND_VERTEX    = 3'd0;
  localparam logic [2:0] KIND_TRANSLATE = 3'd1;
  localparam logic [2:0] KIND_ROT_X     = 3'd2;
  localparam logic [2:0] KIND_ROT_Y     = 3'd3;
  localparam logic [2:0] KIND_ROT_Z     = 3'd4;

  localparam int FQ_DEPTH = 4;
  localparam int OQ_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_VERTEX,
    OP_TRANSLATE,
    OP_ROT_X,
    OP_ROT_Y,
    OP_ROT_Z
  } op_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic [15:0]        turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [15:0]        angle;
  } cmd_t;

endpackage

FILE: rtl/core/mtme_front.sv
// ----------------------------------------------------------------------------
// Transform matrix engine front end
// Accepts items, decodes the kind, drops unknown kinds and queues commands.
// ----------------------------------------------------------------------------
module mtme_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  mtme_pkg::in_item_t in_item,
  output logic              head_valid,
  output mtme_pkg::cmd_t    head,
  input  logic              head_pop
);
  import mtme_pkg::*;

  localparam int PTR_W = $clog2(FQ_DEPTH);

  cmd_t             q_r [FQ_DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W:0]   cnt_r;
  logic [PTR_W:0]   cnt_nxt;
  cmd_t             cmd;
  logic             known;
  logic             push;

  always_comb begin
    cmd.x     = in_item.in_x;
    cmd.y     = in_item.in_y;
    cmd.z     = in_item.in_z;
    cmd.w     = in_item.in_w;
    cmd.angle = in_item.turn_angle;
    cmd.op    = OP_VERTEX;
    known     = 1'b1;
    case (in_item.kind)
      KIND_VERTEX:    cmd.op = OP_VERTEX;
      KIND_TRANSLATE: cmd.op = OP_TRANSLATE;
      KIND_ROT_X:     cmd.op = OP_ROT_X;
      KIND_ROT_Y:     cmd.op = OP_ROT_Y;
      KIND_ROT_Z:     cmd.op = OP_ROT_Z;
      default:        known  = 1'b0;
    endcase
  end

  assign in_full    = (cnt_r == (PTR_W+1)'(FQ_DEPTH));
  assign push       = in_push && !in_full && known;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !head_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && head_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (head_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cmd;
    end
  end

endmodule

FILE: rtl/core/mtme_vtx.sv
// ----------------------------------------------------------------------------
// Transform matrix engine vertex pipe
// Three-stage v * M datapath with rounding, saturation and a result queue.
// ----------------------------------------------------------------------------
module mtme_vtx #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        issue,
  output logic                        ready,
  input  mtme_pkg::cmd_t              cmd,
  input  logic signed [WORD_BITS-1:0] mat [4][4],
  output logic                        out_empty,
  input  logic                        out_pop,
  output mtme_pkg::out_item_t         out_item
);
  import mtme_pkg::*;

  localparam int LM    = WORD_BITS / 2;
  localparam int HM    = WORD_BITS - LM;
  localparam int PLW   = 32 + LM + 1;
  localparam int PHW   = 32 + HM;
  localparam int PRW   = 32 + WORD_BITS;
  localparam int SW    = PRW + 3;
  localparam int PTR_W = $clog2(OQ_DEPTH);
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] OMAX = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] OMIN = ~OMAX;

  logic signed [31:0]     v [4];
  logic signed [PLW-1:0]  plo_r  [4][4];
  logic signed [PHW-1:0]  phi_r  [4][4];
  logic signed [PRW-1:0]  prod_r [4][4];
  logic signed [SW-1:0]   sum_r  [4];
  logic signed [SW-1:0]   sh     [4];
  logic signed [31:0]     res    [4];
  logic [2:0]             vld_r;
  logic                   en;
  logic                   oq_push;
  out_item_t              oq_r [OQ_DEPTH];
  logic [PTR_W-1:0]       wr_r;
  logic [PTR_W-1:0]       rd_r;
  logic [PTR_W:0]         cnt_r;
  logic                   oq_full;
  logic                   do_pop;

  assign v[0] = cmd.x;
  assign v[1] = cmd.y;
  assign v[2] = cmd.z;
  assign v[3] = cmd.w;

  assign oq_full   = (cnt_r == (PTR_W+1)'(OQ_DEPTH));
  assign en        = !oq_full;
  assign ready     = en;
  assign oq_push   = vld_r[2] && en;
  assign out_empty = (cnt_r == '0);
  assign do_pop    = out_pop && !out_empty;
  assign out_item  = oq_r[rd_r];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          plo_r[i][j]  <= v[i] * $signed({1'b0, mat[i][j][LM-1:0]});
          phi_r[i][j]  <= v[i] * $signed(mat[i][j][WORD_BITS-1:LM]);
          prod_r[i][j] <= (PRW'(phi_r[i][j]) <<< LM) + PRW'(plo_r[i][j]);
        end
      end
      for (int j = 0; j < 4; j++) begin
        sum_r[j] <= SW'(prod_r[0][j]) + SW'(prod_r[1][j]) + SW'(prod_r[2][j])
                  + SW'(prod_r[3][j]) + HALF;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sh[j] = sum_r[j] >>> FRAC_BITS;
      if (sh[j] > OMAX) begin
        res[j] = 32'sh7fff_ffff;
      end else if (sh[j] < OMIN) begin
        res[j] = 32'sh8000_0000;
      end else begin
        res[j] = sh[j][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[1:0], issue};
      end
      if (oq_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (oq_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!oq_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[wr_r] <= '{out_x: res[0], out_y: res[1], out_z: res[2], out_w: res[3]};
    end
  end

endmodule

FILE: rtl/core/mtme_upd.sv
// ----------------------------------------------------------------------------
// Transform matrix engine matrix unit
// Holds the matrix and post-multiplies it by translate or rotate matrices,
// one row per pass through a three-stage multiply, add, round pipeline.
// ----------------------------------------------------------------------------
module mtme_upd #(
  parameter int WORD_BITS        = 32,
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  mtme_pkg::cmd_t              cmd,
  output logic                        busy,
  output logic signed [WORD_BITS-1:0] mat [4][4]
);
  import mtme_pkg::*;

  localparam int E     = FRAC_BITS + 2;
  localparam int CW    = (WORD_BITS > E) ? WORD_BITS : E;
  localparam int LA    = WORD_BITS / 2;
  localparam int HA    = WORD_BITS - LA;
  localparam int LB    = CW / 2;
  localparam int HB    = CW - LB;
  localparam int PW    = WORD_BITS + CW;
  localparam int SW    = PW + 2;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int MW    = ANGLE_BITS + IDX_W + 1;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint WMAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;

  localparam logic signed [CW-1:0]        ONE_C = CW'(1) <<< FRAC_BITS;
  localparam logic signed [WORD_BITS-1:0] ONE_W = WORD_BITS'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0]        HALF  = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SMAX = {{(SW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  typedef longint unsigned tdiv_arr_t [60];
  typedef logic [2*E-1:0]  rom_arr_t [SINE_TABLE_DEPTH];

  function automatic tdiv_arr_t build_div();
    tdiv_arr_t d;
    for (int n = 0; n < 60; n++) begin
      d[n] = longint'((n + 1) * (n + 2)) << 30;
    end
    return d;
  endfunction

  localparam tdiv_arr_t TAYLOR_DIV = build_div();

  function automatic longint taylor_q30(longint unsigned x, longint unsigned x2,
                                        bit is_sin);
    longint unsigned term;
    longint          sum;
    int              n;
    bit              neg;
    term = is_sin ? x : Q30_ONE;
    sum  = longint'(term);
    n    = is_sin ? 1 : 0;
    neg  = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (term != 0 && n < 60) begin
        term = (term * x2) / TAYLOR_DIV[n];
        sum  = neg ? sum - longint'(term) : sum + longint'(term);
        neg  = !neg;
        n    = n + 2;
      end
    end
    return sum;
  endfunction

  function automatic longint q30_to_fix(longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > longint'(Q30_ONE)) c = longint'(Q30_ONE);
    return (c + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t        rom;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint          s;
    longint          c;
    longint          sv;
    longint          cv;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q  = (64'd4 * longint'(k)) / SINE_TABLE_DEPTH;
      r  = 64'd4 * longint'(k) - q * SINE_TABLE_DEPTH;
      x  = (PI_HALF_Q30 * r) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      s  = q30_to_fix(taylor_q30(x, x2, 1'b1));
      c  = q30_to_fix(taylor_q30(x, x2, 1'b0));
      case (q[1:0])
        2'd0:    begin sv = s;  cv = c;  end
        2'd1:    begin sv = c;  cv = -s; end
        2'd2:    begin sv = -s; cv = -c; end
        default: begin sv = -c; cv = s;  end
      endcase
      rom[k] = {E'(sv), E'(cv)};
    end
    return rom;
  endfunction

  localparam rom_arr_t SINCOS_ROM = build_rom();

  function automatic logic signed [WORD_BITS-1:0] sat_w(logic signed [31:0] v);
    longint lv;
    lv = v;
    if (lv > WMAX) lv = WMAX;
    if (lv < WMIN) lv = WMIN;
    return WORD_BITS'(lv);
  endfunction

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_ADD, U_SUM} ustate_t;

  ustate_t                      state_r;
  op_t                          op_r;
  logic [1:0]                   row_r;
  logic signed [WORD_BITS-1:0]  t_r [3];
  logic [2*E-1:0]               sc_r;
  logic signed [WORD_BITS-1:0]  mat_r [4][4];
  logic signed [HA+HB-1:0]      hh_r [2][4];
  logic signed [HA+LB:0]        hl_r [2][4];
  logic signed [LA+HB:0]        lh_r [2][4];
  logic [LA+LB-1:0]             ll_r [2][4];
  logic signed [PW-1:0]         prod_r [2][4];
  logic signed [WORD_BITS-1:0]  opnd [2][4];
  logic signed [CW-1:0]         coef [2][4];
  logic signed [CW-1:0]         s_c;
  logic signed [CW-1:0]         c_c;
  logic [1:0]                   rp;
  logic [1:0]                   rq;
  logic signed [SW-1:0]         sum [4];
  logic signed [SW-1:0]         sh  [4];
  logic signed [WORD_BITS-1:0]  new_row [4];
  logic [ANGLE_BITS-1:0]        ang;
  logic [MW-1:0]                idx_full;
  logic [IDX_W-1:0]             idx;

  assign ang      = cmd.angle[ANGLE_BITS-1:0];
  assign idx_full = MW'(ang) * MW'(SINE_TABLE_DEPTH);
  assign idx      = idx_full[ANGLE_BITS +: IDX_W];
  assign busy     = (state_r != U_IDLE);
  assign mat      = mat_r;

  always_comb begin
    s_c = CW'($signed(sc_r[2*E-1:E]));
    c_c = CW'($signed(sc_r[E-1:0]));
    if (op_r == OP_ROT_Y) begin
      s_c = -s_c;
    end
    rp = 2'd0;
    rq = 2'd1;
    for (int j = 0; j < 4; j++) begin
      opnd[0][j] = mat_r[0][j];
      coef[0][j] = ONE_C;
      opnd[1][j] = mat_r[0][j];
      coef[1][j] = '0;
    end
    case (op_r)
      OP_TRANSLATE: begin
        for (int j = 0; j < 3; j++) begin
          opnd[1][j] = mat_r[0][3];
          coef[1][j] = CW'(t_r[j]);
        end
      end
      OP_ROT_X, OP_ROT_Y, OP_ROT_Z: begin
        case (op_r)
          OP_ROT_X: begin rp = 2'd1; rq = 2'd2; end
          OP_ROT_Y: begin rp = 2'd0; rq = 2'd2; end
          default:  begin rp = 2'd0; rq = 2'd1; end
        endcase
        opnd[0][rp] = mat_r[0][rp];
        coef[0][rp] = c_c;
        opnd[1][rp] = mat_r[0][rq];
        coef[1][rp] = -s_c;
        opnd[0][rq] = mat_r[0][rp];
        coef[0][rq] = s_c;
        opnd[1][rq] = mat_r[0][rq];
        coef[1][rq] = c_c;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = SW'(prod_r[0][j]) + SW'(prod_r[1][j]) + HALF;
      sh[j]  = sum[j] >>> FRAC_BITS;
      if (sh[j] > SMAX) begin
        new_row[j] = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (sh[j] < SMIN) begin
        new_row[j] = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
        new_row[j] = sh[j][WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      op_r    <= OP_VERTEX;
      row_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          mat_r[i][j] <= (i == j) ? ONE_W : '0;
        end
      end
    end else begin
      case (state_r)
        U_IDLE: begin
          if (start) begin
            op_r    <= cmd.op;
            t_r[0]  <= sat_w(cmd.x);
            t_r[1]  <= sat_w(cmd.y);
            t_r[2]  <= sat_w(cmd.z);
            sc_r    <= SINCOS_ROM[idx];
            row_r   <= '0;
            state_r <= U_MUL;
          end
        end
        U_MUL: begin
          for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 4; j++) begin
              hh_r[k][j] <= $signed(opnd[k][j][WORD_BITS-1:LA])
                          * $signed(coef[k][j][CW-1:LB]);
              hl_r[k][j] <= $signed(opnd[k][j][WORD_BITS-1:LA])
                          * $signed({1'b0, coef[k][j][LB-1:0]});
              lh_r[k][j] <= $signed({1'b0, opnd[k][j][LA-1:0]})
                          * $signed(coef[k][j][CW-1:LB]);
              ll_r[k][j] <= opnd[k][j][LA-1:0] * coef[k][j][LB-1:0];
            end
          end
          state_r <= U_ADD;
        end
        U_ADD: begin
          for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 4; j++) begin
              prod_r[k][j] <= (PW'(hh_r[k][j]) <<< (LA + LB))
                            + (PW'(hl_r[k][j]) <<< LA)
                            + (PW'(lh_r[k][j]) <<< LB)
                            + $signed(PW'(ll_r[k][j]));
            end
          end
          state_r <= U_SUM;
        end
        U_SUM: begin
          mat_r[0] <= mat_r[1];
          mat_r[1] <= mat_r[2];
          mat_r[2] <= mat_r[3];
          for (int j = 0; j < 4; j++) begin
            mat_r[3][j] <= new_row[j];
          end
          row_r   <= row_r + 1'b1;
          state_r <= (row_r == 2'd3) ? U_IDLE : U_MUL;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/model_transform_matrix_engine.sv
// ----------------------------------------------------------------------------
// Model transform matrix engine
// Keeps a 4x4 Q16.16 row-vector transform matrix; vertex items are
// transformed by it, translate and rotate items post-multiply it.
//
// Input channel: in_item is taken when in_push is high and in_full is low.
// Items of an unknown kind are taken and dropped. Items wait in a 4-deep
// command queue; the sender is held up once four items wait behind a busy
// back end.
// Result channel: one result per vertex item, oldest first, on out_item
// while out_empty is low; it is taken when out_pop is high.
// Vertices: one per cycle while the result queue has room and the matrix
// unit is idle; each passes the queue, multiply, add and sum stages.
// Matrix items: in the matrix unit, a sine/cosine lookup, then one row
// per multiply, add, round pass; later vertices wait.
// Reset: synchronous; the matrix returns to the identity, queues empty.
// A stalled receiver fills the 4-deep result queue, which stops the vertex
// pipe and then the command queue, and finally raises in_full.
// ----------------------------------------------------------------------------
module model_transform_matrix_engine #(
  parameter int WORD_BITS        = 32,
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  mtme_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output mtme_pkg::out_item_t out_item
);
  import mtme_pkg::*;

  cmd_t                        head;
  logic                        head_valid;
  logic                        head_pop;
  logic                        vtx_issue;
  logic                        vtx_ready;
  logic                        upd_start;
  logic                        upd_busy;
  logic signed [WORD_BITS-1:0] mat [4][4];

  assign vtx_issue = head_valid && (head.op == OP_VERTEX) && vtx_ready && !upd_busy;
  assign upd_start = head_valid && (head.op != OP_VERTEX) && !upd_busy;
  assign head_pop  = vtx_issue || upd_start;

  mtme_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  mtme_upd #(
    .WORD_BITS        (WORD_BITS),
    .FRAC_BITS        (FRAC_BITS),
    .ANGLE_BITS       (ANGLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_upd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (upd_start),
    .cmd   (head),
    .busy  (upd_busy),
    .mat   (mat)
  );

  mtme_vtx #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_vtx (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (vtx_issue),
    .ready     (vtx_ready),
    .cmd       (head),
    .mat       (mat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  a_no_vtx_during_update: assert property (@(posedge clk) disable iff (!rst_n)
    upd_busy |-> !vtx_issue)
    else $error("vertex issued during matrix update");

  a_one_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !(vtx_issue && upd_start))
    else $error("two commands issued in one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    upd_start |=> upd_busy)
    else $error("matrix unit did not go busy");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

endmodule
